// ===== src/fac_pkg.sv =====
// Package for the flash array controller.
// Holds field widths, command and status codes, default sizes and the
// control/status bundles between the controller and the datapath.
`timescale 1ns / 1ps

package fac_pkg;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;

    localparam int MEM_BYTES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 1024;

    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PROG   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PAGE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MASS   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UNLOCK = 3'd4;
    localparam logic [ACT_W-1:0] ACT_LOCK   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID    = 2'd1;
    localparam logic [STAT_W-1:0] ST_PROTECTED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ERASED = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_step;
        logic page_init;
        logic sweep_write;
        logic sweep_done;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_div;
        logic need_mass;
        logic sweep_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== src/fac_cmd_if.sv =====
// Command channel of the flash array controller.
// Depends on fac_pkg for the field widths.
`timescale 1ns / 1ps

interface fac_cmd_if;
    import fac_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output action, output address, output write_data,
                    input ready);
    modport sink   (input valid, input action, input address, input write_data,
                    output ready);
endinterface

// ===== src/fac_rsp_if.sv =====
// Response channel of the flash array controller.
// Depends on fac_pkg for the field widths.
`timescale 1ns / 1ps

interface fac_rsp_if;
    import fac_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output status, output read_data, input ready);
    modport sink   (input valid, input status, input read_data, output ready);
endinterface

// ===== src/fac_ctrl.sv =====
// Controller state machine of the flash array controller.
// Sequences clear, command, page divide and erase sweep; depends on fac_pkg.
`timescale 1ns / 1ps

module fac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  fac_pkg::t_dp_stat i_stat,
    output fac_pkg::t_ctl_cmd o_cmd
);
    import fac_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SETUP = 3'd4;
    localparam logic [2:0] S_ERASE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_write = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    priority if (i_stat.need_div) begin
                        n_state = S_DIV;
                    end else if (i_stat.need_mass) begin
                        n_state = S_ERASE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.page_init = 1'b1;
                n_state         = S_ERASE;
            end
            S_ERASE: begin
                if (!i_stat.sweep_last) begin
                    o_cmd.sweep_write = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.sweep_write = 1'b1;
                    o_cmd.sweep_done  = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/fac_datapath.sv =====
// Datapath of the flash array controller: byte array, lock flag, page
// quotient multiplier, erase sweep pointer and result register. Uses fac_pkg.
`timescale 1ns / 1ps

module fac_datapath #(
    parameter int MEM_BYTES  = fac_pkg::MEM_BYTES_DEF,
    parameter int PAGE_BYTES = fac_pkg::PAGE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fac_pkg::t_ctl_cmd           i_cmd,
    output fac_pkg::t_dp_stat           o_stat,
    input  logic [fac_pkg::ACT_W-1:0]   i_action,
    input  logic [fac_pkg::ADDR_W-1:0]  i_address,
    input  logic [fac_pkg::DATA_W-1:0]  i_write_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fac_pkg::STAT_W-1:0]  o_status,
    output logic [fac_pkg::DATA_W-1:0]  o_read_data
);
    import fac_pkg::*;

    localparam int AW      = $clog2(MEM_BYTES);
    localparam int PAGE_SH = $clog2(PAGE_BYTES);
    localparam int RCP_SH  = ADDR_W + PAGE_SH;
    localparam int RCP_W   = ADDR_W + 1;
    localparam int PROD_W  = ADDR_W + RCP_W;
    localparam logic [RCP_W-1:0] PAGE_RCP = RCP_W'(
        ((longint'(1) << RCP_SH) + longint'(PAGE_BYTES) - 1) / longint'(PAGE_BYTES));

    logic [DATA_W-1:0] r_mem [MEM_BYTES];
    logic [DATA_W-1:0] r_mem_q;

    logic [ACT_W-1:0]     r_action;
    logic [ADDR_W-1:0]    r_address;
    logic [DATA_W-1:0]    r_wdata;
    logic                 r_lock;
    logic [ADDR_W-1:0]    r_quot;
    logic [AW-1:0]        r_ptr;
    logic [AW-1:0]        r_end;
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [DATA_W-1:0]    r_rdata;

    logic              w_in_range;
    logic [STAT_W-1:0] w_status;
    logic [DATA_W-1:0] w_rdata;
    logic              w_prog_we;
    logic              w_lock_set;
    logic              w_lock_clr;
    logic              w_need_div;
    logic              w_need_mass;
    logic              w_out_free;
    logic [PROD_W-1:0] w_prod;
    logic [ADDR_W-1:0] w_quot;
    logic [ADDR_W-1:0] w_base;
    logic [ADDR_W:0]   w_last;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [DATA_W-1:0] w_mem_wdata;

    assign w_in_range = {1'b0, r_address} < (ADDR_W + 1)'(MEM_BYTES);
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        w_status    = ST_OK;
        w_rdata     = '0;
        w_prog_we   = 1'b0;
        w_lock_set  = 1'b0;
        w_lock_clr  = 1'b0;
        w_need_div  = 1'b0;
        w_need_mass = 1'b0;
        unique case (r_action)
            ACT_READ: begin
                if (!w_in_range) begin
                    w_status = ST_INVALID;
                end else begin
                    w_rdata = r_mem_q;
                end
            end
            ACT_PROG: begin
                priority if (!w_in_range) begin
                    w_status = ST_INVALID;
                end else if (r_lock) begin
                    w_status = ST_PROTECTED;
                end else if (r_mem_q != ERASED_BYTE) begin
                    w_status = ST_NOT_ERASED;
                end else begin
                    w_prog_we = 1'b1;
                end
            end
            ACT_PAGE: begin
                priority if (!w_in_range) begin
                    w_status = ST_INVALID;
                end else if (r_lock) begin
                    w_status = ST_PROTECTED;
                end else begin
                    w_need_div = 1'b1;
                end
            end
            ACT_MASS: begin
                if (r_lock) begin
                    w_status = ST_PROTECTED;
                end else begin
                    w_need_mass = 1'b1;
                end
            end
            ACT_UNLOCK: begin
                w_lock_clr = 1'b1;
            end
            ACT_LOCK: begin
                w_lock_set = 1'b1;
            end
            default: begin
                w_status = ST_INVALID;
            end
        endcase
    end

    assign o_stat.need_div   = w_need_div;
    assign o_stat.need_mass  = w_need_mass;
    assign o_stat.sweep_last = (r_ptr == r_end);
    assign o_stat.out_free   = w_out_free;

    // page number by reciprocal multiplication, exact over the address range
    assign w_prod = PROD_W'(r_address) * PROD_W'(PAGE_RCP);
    assign w_quot = ADDR_W'(w_prod >> RCP_SH);

    assign w_base = r_quot * ADDR_W'(PAGE_BYTES);
    assign w_last = {1'b0, w_base} + (ADDR_W + 1)'(PAGE_BYTES - 1);

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_ptr;
        w_mem_wdata = ERASED_BYTE;
        if (i_cmd.sweep_write) begin
            w_mem_we = 1'b1;
        end else if (i_cmd.exec && w_prog_we) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_address[AW-1:0];
            w_mem_wdata = r_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (i_cmd.load) begin
            r_mem_q <= r_mem[i_address[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_address <= i_address;
            r_wdata   <= i_write_data;
        end
        if (i_cmd.exec) begin
            r_status <= w_status;
            r_rdata  <= w_rdata;
        end else if (i_cmd.sweep_done) begin
            r_status <= ST_OK;
            r_rdata  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock      <= 1'b1;
            r_quot      <= '0;
            r_ptr       <= '0;
            r_end       <= AW'(MEM_BYTES - 1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec && w_lock_set) begin
                r_lock <= 1'b1;
            end else if (i_cmd.exec && w_lock_clr) begin
                r_lock <= 1'b0;
            end

            if (i_cmd.div_step) begin
                r_quot <= w_quot;
            end

            priority if (i_cmd.exec && w_need_mass) begin
                r_ptr <= '0;
                r_end <= AW'(MEM_BYTES - 1);
            end else if (i_cmd.page_init) begin
                r_ptr <= w_base[AW-1:0];
                if (w_last >= (ADDR_W + 1)'(MEM_BYTES)) begin
                    r_end <= AW'(MEM_BYTES - 1);
                end else begin
                    r_end <= w_last[AW-1:0];
                end
            end else if (i_cmd.sweep_write && (r_ptr != r_end)) begin
                r_ptr <= r_ptr + 1'b1;
            end

            if ((i_cmd.exec && !w_need_div && !w_need_mass) || i_cmd.sweep_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_read_data = r_rdata;

    a_lock_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_lock))
        else $error("lock flag changed without a command");

    a_sweep_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_end)
        else $error("erase pointer passed the sweep end");

    a_base_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.page_init |-> (w_base <= r_address && {1'b0, r_address} <= w_last))
        else $error("page base does not hold the address");

    a_prog_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_prog_we) |-> (!r_lock && !i_cmd.sweep_write))
        else $error("program write while locked or during a sweep");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep_done || (i_cmd.exec && !w_need_div && !w_need_mass))
            |-> w_out_free)
        else $error("result loaded over an unread result");

endmodule

// ===== src/flash_array_controller.sv =====
// Channel     Dir  Fields                               Handshake
// i_cmd       in   action[2:0] address[15:0] write_data  valid/ready
// o_rsp       out  status[1:0] read_data[7:0]           valid/ready
//
// After reset the array is swept to 0xFF, one byte a cycle, with i_cmd.ready
// low. Read, program, lock and unlock are accepted with an array read and then
// executed. Page erase is accepted and executed, then takes a page number step,
// a setup step and a sweep over the page; mass erase is accepted and executed,
// then swept over the whole array; both sweeps use the single array write port.
// The result register holds one response; a stalled o_rsp lets the next
// transaction in and holds its completion until the register frees.
`timescale 1ns / 1ps

module flash_array_controller #(
    parameter int MEM_BYTES  = fac_pkg::MEM_BYTES_DEF,
    parameter int PAGE_BYTES = fac_pkg::PAGE_BYTES_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    fac_cmd_if.sink   i_cmd,
    fac_rsp_if.source o_rsp
);
    import fac_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;
    logic     w_cmd_ready;

    fac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fac_datapath #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_action     (i_cmd.action),
        .i_address    (i_cmd.address),
        .i_write_data (i_cmd.write_data),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_status     (o_rsp.status),
        .o_read_data  (o_rsp.read_data)
    );

    assign i_cmd.ready = w_cmd_ready;

endmodule

// ===== tb/flash_array_controller_checker.sv =====
`timescale 1ns / 1ps
// Checker for the flash array controller: watches both channels, keeps its own
// copy of the array and the lock, and compares every response with its command.
// Depends on fac_pkg and on the fac_cmd_if and fac_rsp_if interfaces.

module flash_array_controller_checker #(
    parameter int MEM_BYTES  = fac_pkg::MEM_BYTES_DEF,
    parameter int PAGE_BYTES = fac_pkg::PAGE_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fac_cmd_if   i_cmd,
    fac_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_outstanding
);
    import fac_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_data;
    } t_flash_rsp;

    logic [DATA_W-1:0] array_copy [MEM_BYTES];
    logic              locked;
    t_flash_rsp        rsp_expected_q [$];
    t_flash_rsp        predicted;
    t_flash_rsp        oldest;

    task automatic report_mismatch(input string msg);
        o_mismatches++;
        $display("%0t flash_array_controller mismatch: %s", $time, msg);
    endtask

    task automatic execute_command(input logic [ACT_W-1:0] action,
                                   input logic [ADDR_W-1:0] address,
                                   input logic [DATA_W-1:0] wdata,
                                   output t_flash_rsp rsp);
        int base;
        bit in_range;
        in_range      = int'(address) < MEM_BYTES;
        rsp.status    = ST_OK;
        rsp.read_data = '0;
        case (action)
            ACT_READ: begin
                if (!in_range) rsp.status = ST_INVALID;
                else rsp.read_data = array_copy[address];
            end
            ACT_PROG: begin
                if (!in_range) rsp.status = ST_INVALID;
                else if (locked) rsp.status = ST_PROTECTED;
                else if (array_copy[address] != ERASED_BYTE) rsp.status = ST_NOT_ERASED;
                else array_copy[address] = wdata;
            end
            ACT_PAGE: begin
                if (!in_range) begin
                    rsp.status = ST_INVALID;
                end else if (locked) begin
                    rsp.status = ST_PROTECTED;
                end else begin
                    base = (int'(address) / PAGE_BYTES) * PAGE_BYTES;
                    // stop at the end of the array on a partial last page
                    for (int i = 0; i < PAGE_BYTES && base + i < MEM_BYTES; i++) begin
                        array_copy[base + i] = ERASED_BYTE;
                    end
                end
            end
            ACT_MASS: begin
                if (locked) begin
                    rsp.status = ST_PROTECTED;
                end else begin
                    foreach (array_copy[i]) array_copy[i] = ERASED_BYTE;
                end
            end
            ACT_UNLOCK: begin
                locked = 1'b0;
            end
            ACT_LOCK: begin
                locked = 1'b1;
            end
            default: begin
                rsp.status = ST_INVALID;
            end
        endcase
    endtask

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        locked        = 1'b1;
        foreach (array_copy[i]) array_copy[i] = ERASED_BYTE;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_expected_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "response status %0d data 0x%02h with no command outstanding",
                        i_rsp.status, i_rsp.read_data));
                end else begin
                    oldest = rsp_expected_q.pop_front();
                    if (i_rsp.status !== oldest.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_rsp.status, oldest.status));
                    end
                    if (i_rsp.read_data !== oldest.read_data) begin
                        report_mismatch($sformatf("read_data 0x%02h, expected 0x%02h",
                                                  i_rsp.read_data, oldest.read_data));
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                execute_command(i_cmd.action, i_cmd.address, i_cmd.write_data, predicted);
                rsp_expected_q.push_back(predicted);
            end
            o_outstanding = rsp_expected_q.size();
        end
    end

endmodule

// ===== tb/flash_array_controller_test.sv =====
`timescale 1ns / 1ps
// Top of the flash array controller test: clock, reset, command stimulus,
// response back-pressure and the verdict. Uses fac_pkg, the channel
// interfaces, the controller and flash_array_controller_checker.

module flash_array_controller_test;
    import fac_pkg::*;

    localparam int MEM_BYTES      = MEM_BYTES_DEF;
    localparam int PAGE_BYTES     = PAGE_BYTES_DEF;
    localparam int NUM_RANDOM     = 1825;
    localparam int MASS_ERASE_CAP = 8;
    localparam int DRAIN_CYCLES   = 50;

    localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;

    localparam logic [ADDR_W-1:0] ADDR_LAST    = ADDR_W'(MEM_BYTES - 1);
    localparam logic [ADDR_W-1:0] ADDR_PAST    = ADDR_W'(MEM_BYTES);
    localparam logic [ADDR_W-1:0] ADDR_TOP     = '1;
    localparam logic [ADDR_W-1:0] ADDR_PAGE1   = ADDR_W'(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] ADDR_PAGE0_E = ADDR_W'(PAGE_BYTES - 1);

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   mismatches;
    int   outstanding;

    fac_cmd_if cmd_ch ();
    fac_rsp_if rsp_ch ();

    flash_array_controller #(
        .MEM_BYTES (MEM_BYTES),
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    flash_array_controller_checker #(
        .MEM_BYTES (MEM_BYTES),
        .PAGE_BYTES(PAGE_BYTES)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic send_cmd(input logic [ACT_W-1:0] action,
                            input logic [ADDR_W-1:0] address,
                            input logic [DATA_W-1:0] wdata);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= action;
        cmd_ch.address    <= address;
        cmd_ch.write_data <= wdata;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int sel;
        int base;
        sel = $urandom_range(0, 9);
        if (sel == 0) return ADDR_W'($urandom_range(0, 65535));
        if (sel == 1) return ADDR_W'(MEM_BYTES - 4 + $urandom_range(0, 7));
        case ($urandom_range(0, 2))
            0: base = 0;
            1: base = PAGE_BYTES - 16;
            default: base = MEM_BYTES - 32;
        endcase
        return ADDR_W'(base + $urandom_range(0, 31));
    endfunction

    // response side: hold ready low for a drawn stall before each transaction
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int                mass_erases;
        int                r;
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] wdata;
        cmd_ch.valid      = 1'b0;
        cmd_ch.action     = ACT_READ;
        cmd_ch.address    = '0;
        cmd_ch.write_data = '0;
        no_idle           = 1'b0;
        mass_erases       = 0;
        i_rst_n           = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // locked array after reset
        send_cmd(ACT_READ, '0, 8'h00);
        send_cmd(ACT_READ, ADDR_LAST, 8'h00);
        send_cmd(ACT_READ, ADDR_PAST, 8'h00);
        send_cmd(ACT_READ, ADDR_TOP, 8'h00);
        send_cmd(ACT_PROG, '0, 8'h00);
        send_cmd(ACT_PROG, ADDR_PAST, 8'h00);
        send_cmd(ACT_PAGE, '0, 8'h00);
        send_cmd(ACT_PAGE, ADDR_TOP, 8'h00);
        send_cmd(ACT_MASS, '0, 8'h00);
        send_cmd(ACT_LOCK, '0, 8'h00);
        // unlocked: program once, refuse a second program, undefined actions, page and mass erase
        send_cmd(ACT_UNLOCK, '0, 8'h00);
        send_cmd(ACT_UNLOCK, ADDR_TOP, 8'hFF);
        send_cmd(ACT_PROG, '0, 8'h00);
        send_cmd(ACT_PROG, '0, 8'h55);
        send_cmd(ACT_READ, '0, 8'h00);
        send_cmd(ACT_PROG, ADDR_LAST, 8'hA5);
        send_cmd(ACT_PROG, ADDR_TOP, 8'hFF);
        send_cmd(ACT_PROG, 16'd1, 8'hFF);
        send_cmd(ACT_PROG, 16'd1, 8'h12);
        send_cmd(ACT_PROG, ADDR_PAGE1, 8'h3C);
        send_cmd(ACT_PAGE, ADDR_PAGE0_E, 8'h00);
        send_cmd(ACT_READ, 16'd1, 8'h00);
        send_cmd(ACT_READ, ADDR_PAGE1, 8'h00);
        send_cmd(ACT_UNDEF_LO, ADDR_W'($urandom), 8'h00);
        send_cmd(ACT_UNDEF_HI, ADDR_TOP, 8'hFF);
        send_cmd(ACT_MASS, ADDR_TOP, 8'h00);
        send_cmd(ACT_READ, ADDR_PAGE1, 8'h00);
        send_cmd(ACT_LOCK, '0, 8'h00);
        send_cmd(ACT_READ, ADDR_LAST, 8'h00);

        for (int idx = 0; idx < NUM_RANDOM; idx++) begin
            no_idle = ((idx / 200) % 4) == 2;
            r       = $urandom_range(0, 999);
            if (r < 350) act = ACT_READ;
            else if (r < 700) act = ACT_PROG;
            else if (r < 740) act = ACT_PAGE;
            else if (r < 745) act = ACT_MASS;
            else if (r < 830) act = ACT_UNLOCK;
            else if (r < 860) act = ACT_LOCK;
            else if (r < 890) act = ACT_W'($urandom_range(6, 7));
            else act = ACT_W'($urandom_range(0, 7));
            // keep the slow full-array sweeps rare
            if (act == ACT_MASS) begin
                if (mass_erases >= MASS_ERASE_CAP) act = ACT_READ;
                else mass_erases++;
            end
            wdata = ($urandom_range(0, 7) == 0) ? ERASED_BYTE : DATA_W'($urandom);
            send_cmd(act, pick_address(), wdata);
        end
        cmd_ch.valid <= 1'b0;
        no_idle = 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("flash_array_controller regression: pass");
        end else begin
            $display("flash_array_controller regression: fail");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("flash_array_controller regression: fail");
        $finish;
    end

endmodule
